// File: design/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared widths, types and helpers for the ray-crossing point-in-polygon core.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int COORD_BITS    = 16;
  localparam int DIFF_BITS     = COORD_BITS + 1;
  localparam int PROD_BITS     = 2 * DIFF_BITS;
  localparam int CROSS_BITS    = PROD_BITS + 1;
  localparam int IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int POS_BITS      = 2;
  localparam int OUT_DATA_BITS = ((POS_BITS + 7) / 8) * 8;

  localparam logic [POS_BITS-1:0] POS_OUTSIDE  = 2'd0;
  localparam logic [POS_BITS-1:0] POS_INSIDE   = 2'd1;
  localparam logic [POS_BITS-1:0] POS_BOUNDARY = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;
  typedef logic [POS_BITS-1:0]          pos_t;

  // edge end points relative to the query point: A = a - q, B = b - q
  typedef struct packed {
    logic  valid;
    diff_t ax;
    diff_t ay;
    diff_t bx;
    diff_t by;
  } edge_ops_t;

  typedef struct packed {
    logic  valid;
    prod_t p_axby;
    prod_t p_aybx;
    logic  in_box;      // query within the edge's x and y bounds
    logic  y_straddle;  // half-open straddle of the ray's y
    logic  b_above;     // By > Ay
  } edge_prod_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } item_ctl_t;

  function automatic diff_t coord_sub(coord_t a, coord_t b);
    diff_t ea;
    diff_t eb;
    ea = {a[COORD_BITS-1], a};
    eb = {b[COORD_BITS-1], b};
    return ea - eb;
  endfunction

  // {on_edge, crosses_ray} for one evaluated edge
  function automatic logic [1:0] edge_verdict(edge_prod_t p);
    cross_t c;
    logic   zero;
    c    = cross_t'(p.p_axby) - cross_t'(p.p_aybx);
    zero = (c == '0);
    return {p.valid && zero && p.in_box,
            p.valid && p.y_straddle && !zero && (c[CROSS_BITS-1] == p.b_above)};
  endfunction

endpackage

// File: design/pip_front.sv
// ----------------------------------------------------------------------------
// pip_front
// Input register: tracks the polygon run and forms both edges' operands.
// ----------------------------------------------------------------------------
module pip_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic                              advance,
  input  logic [pip_pkg::IN_DATA_BITS-1:0]  in_data,
  input  logic                              in_last,
  output pip_pkg::item_ctl_t                ctl,
  output pip_pkg::edge_ops_t                edge_prev,
  output pip_pkg::edge_ops_t                edge_close
);

  localparam int CB = pip_pkg::COORD_BITS;

  pip_pkg::coord_t qx_in, qy_in, vx_in, vy_in;
  pip_pkg::coord_t qx, qy, fx, fy;
  pip_pkg::coord_t held_qx_r, held_qy_r, first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic            run_r;
  pip_pkg::item_ctl_t ctl_r;
  pip_pkg::edge_ops_t e_prev_r, e_close_r;

  assign qx_in = in_data[CB-1:0];
  assign qy_in = in_data[2*CB-1:CB];
  assign vx_in = in_data[3*CB-1:2*CB];
  assign vy_in = in_data[4*CB-1:3*CB];

  // first vertex of a run brings the query point along
  assign qx = run_r ? held_qx_r : qx_in;
  assign qy = run_r ? held_qy_r : qy_in;
  assign fx = run_r ? first_x_r : vx_in;
  assign fy = run_r ? first_y_r : vy_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r           <= 1'b0;
      ctl_r.valid     <= 1'b0;
      e_prev_r.valid  <= 1'b0;
      e_close_r.valid <= 1'b0;
      held_qx_r       <= '0;
      held_qy_r       <= '0;
      first_x_r       <= '0;
      first_y_r       <= '0;
      prev_x_r        <= '0;
      prev_y_r        <= '0;
    end else begin
      if (advance) begin
        ctl_r.valid     <= accept;
        e_prev_r.valid  <= accept && run_r;
        e_close_r.valid <= accept && in_last;
      end
      if (accept) begin
        run_r     <= !in_last;
        held_qx_r <= qx;
        held_qy_r <= qy;
        first_x_r <= fx;
        first_y_r <= fy;
        prev_x_r  <= vx_in;
        prev_y_r  <= vy_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctl_r.first  <= !run_r;
      ctl_r.last   <= in_last;
      e_prev_r.ax  <= pip_pkg::coord_sub(prev_x_r, qx);
      e_prev_r.ay  <= pip_pkg::coord_sub(prev_y_r, qy);
      e_prev_r.bx  <= pip_pkg::coord_sub(vx_in, qx);
      e_prev_r.by  <= pip_pkg::coord_sub(vy_in, qy);
      e_close_r.ax <= pip_pkg::coord_sub(vx_in, qx);
      e_close_r.ay <= pip_pkg::coord_sub(vy_in, qy);
      e_close_r.bx <= pip_pkg::coord_sub(fx, qx);
      e_close_r.by <= pip_pkg::coord_sub(fy, qy);
    end
  end

  assign ctl        = ctl_r;
  assign edge_prev  = e_prev_r;
  assign edge_close = e_close_r;

endmodule

// File: design/pip_edge_eval.sv
// ----------------------------------------------------------------------------
// pip_edge_eval
// Cross-product terms and bound flags of one edge, registered.
// ----------------------------------------------------------------------------
module pip_edge_eval (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  pip_pkg::edge_ops_t  ops,
  output pip_pkg::edge_prod_t prod
);

  localparam int DB = pip_pkg::DIFF_BITS;

  pip_pkg::edge_prod_t prod_r;
  logic x_in, y_in;

  // zero lies between the two relative coordinates, ends included
  assign x_in = (ops.ax[DB-1] || ops.ax == '0) != (ops.bx[DB-1] || ops.bx == '0)
                || ops.ax == '0 || ops.bx == '0;
  assign y_in = (ops.ay[DB-1] || ops.ay == '0) != (ops.by[DB-1] || ops.by == '0)
                || ops.ay == '0 || ops.by == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r.valid <= 1'b0;
    end else if (load) begin
      prod_r.valid <= ops.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r.p_axby     <= pip_pkg::PROD_BITS'(ops.ax * ops.by);
      prod_r.p_aybx     <= pip_pkg::PROD_BITS'(ops.ay * ops.bx);
      prod_r.in_box     <= x_in && y_in;
      // one end strictly above the ray, the other on or below it
      prod_r.y_straddle <= (ops.by > 0 && ops.ay <= 0) || (ops.ay > 0 && ops.by <= 0);
      prod_r.b_above    <= ops.by > ops.ay;
    end
  end

  assign prod = prod_r;

endmodule

// File: design/pip_result.sv
// ----------------------------------------------------------------------------
// pip_result
// Parity / boundary accumulation and the result word register.
// ----------------------------------------------------------------------------
module pip_result (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  pip_pkg::item_ctl_t                 ctl,
  input  pip_pkg::edge_prod_t                prod_prev,
  input  pip_pkg::edge_prod_t                prod_close,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [pip_pkg::OUT_DATA_BITS-1:0]  out_data
);

  logic [1:0]    v_prev, v_close;
  logic          parity_r, parity_nxt, hit_r, hit_nxt;
  logic          out_valid_r;
  pip_pkg::pos_t pos_r, pos_nxt;

  assign v_prev  = pip_pkg::edge_verdict(prod_prev);
  assign v_close = pip_pkg::edge_verdict(prod_close);

  assign parity_nxt = (parity_r && !ctl.first) ^ v_prev[0] ^ v_close[0];
  assign hit_nxt    = (hit_r && !ctl.first) || v_prev[1] || v_close[1];
  assign pos_nxt    = hit_nxt    ? pip_pkg::POS_BOUNDARY :
                      parity_nxt ? pip_pkg::POS_INSIDE : pip_pkg::POS_OUTSIDE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r    <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        parity_r <= parity_nxt;
        hit_r    <= hit_nxt;
      end
      if (load && ctl.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && ctl.last) begin
      pos_r <= pos_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = {{(pip_pkg::OUT_DATA_BITS - pip_pkg::POS_BITS){1'b0}}, pos_r};

endmodule

// File: design/point_in_polygon_ray_crossing_core.sv
// ----------------------------------------------------------------------------
// point_in_polygon_ray_crossing_core
// Streamed ray-crossing point-in-polygon test, one vertex word per cycle unless a closing word waits on a held result.
// ----------------------------------------------------------------------------
// Path: the input reg loads on the accept edge, then the product reg, then
//   the result reg raises out_tvalid; it waits only while the result word is held.
// Throughput: 1 vertex word per cycle unless a closing word waits on a held
//   result word; both edges of a closing vertex are evaluated side by side
//   by two product units, so a closing vertex does not slow the stream.
// Reset (rst_n low, synchronous): pipeline and result emptied, run state
//   cleared so the next word starts a new polygon.
// ----------------------------------------------------------------------------
module point_in_polygon_ray_crossing_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // query_x [15:0], query_y [31:16], vertex_x [47:32], vertex_y [63:48]
  input  logic [pip_pkg::IN_DATA_BITS-1:0]   in_tdata,
  input  logic                               in_tlast,   // last_vertex
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // position [1:0], zero padded
  output logic [pip_pkg::OUT_DATA_BITS-1:0]  out_tdata
);

  pip_pkg::item_ctl_t  s1_ctl, s2_ctl_r;
  pip_pkg::edge_ops_t  s1_prev, s1_close;
  pip_pkg::edge_prod_t s2_prev, s2_close;
  logic                accept, out_free, s2_adv, s1_adv;

  // A word in stage 2 only needs the result register if it closes a polygon;
  // inner vertices drain freely, so input keeps flowing while a result waits.
  assign out_free  = !out_tvalid || out_tready;
  assign s2_adv    = !s2_ctl_r.valid || !s2_ctl_r.last || out_free;
  assign s1_adv    = !s1_ctl.valid || s2_adv;
  assign in_tready = s1_adv;
  assign accept    = in_tvalid && in_tready;

  // stage 1: run tracking, edge operands relative to the query point
  pip_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .advance    (s1_adv),
    .in_data    (in_tdata),
    .in_last    (in_tlast),
    .ctl        (s1_ctl),
    .edge_prev  (s1_prev),
    .edge_close (s1_close)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r.valid <= 1'b0;
    end else if (s2_adv) begin
      s2_ctl_r.valid <= s1_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_ctl_r.first <= s1_ctl.first;
      s2_ctl_r.last  <= s1_ctl.last;
    end
  end

  // stage 2: edge from the previous vertex, and the closing edge to the first
  pip_edge_eval u_eval_prev (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (s2_adv),
    .ops   (s1_prev),
    .prod  (s2_prev)
  );

  pip_edge_eval u_eval_close (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (s2_adv),
    .ops   (s1_close),
    .prod  (s2_close)
  );

  // stage 3: sign tests, parity and boundary, result word
  pip_result u_result (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s2_ctl_r.valid && s2_adv),
    .ctl        (s2_ctl_r),
    .prod_prev  (s2_prev),
    .prod_close (s2_close),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_data   (out_tdata)
  );

endmodule

// File: design/pip_checker.sv
// ----------------------------------------------------------------------------
// pip_checker
// Port-level checks for the point-in-polygon core, bound to the top level.
// ----------------------------------------------------------------------------
module pip_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [pip_pkg::OUT_DATA_BITS-1:0]  out_tdata
);

  // held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // position is outside, inside or boundary, padding zero
  a_out_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == pip_pkg::POS_OUTSIDE ||
                    out_tdata[1:0] == pip_pkg::POS_INSIDE  ||
                    out_tdata[1:0] == pip_pkg::POS_BOUNDARY) &&
                   out_tdata[pip_pkg::OUT_DATA_BITS-1:pip_pkg::POS_BITS] == '0)
    else $error("bad position code");

  // with no result pending nothing can block the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind point_in_polygon_ray_crossing_core pip_checker u_pip_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ray-crossing point-in-polygon core. Polygons
// are streamed one vertex word at a time, with the query point carried on the
// first word. A bench-side model tracks parity and boundary hits per edge.
// Each position word is checked against the oldest prediction in order.
// Both sides idle at random. There is one calm stretch, and the sender stops
// now and then until every prediction has been matched.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STALL_LIMIT = 1000;   // cycles with no handshake on either side
  localparam int TARGET_WORDS = 1850;

  // coordinate spread used when building a random polygon
  typedef enum int {SPAN_FULL, SPAN_TINY, SPAN_EXTREME, SPAN_MID} span_e;

  logic                              clk;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  // query_x, query_y, vertex_x, vertex_y
  logic [pip_pkg::IN_DATA_BITS-1:0]  in_tdata;
  logic                              in_tlast;   // last_vertex
  logic                              out_tvalid;
  logic                              out_tready;
  logic [pip_pkg::OUT_DATA_BITS-1:0] out_tdata;  // position, zero padded

  point_in_polygon_ray_crossing_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // bench copy of the run state
  longint run_qx, run_qy, run_first_x, run_first_y, run_prev_x, run_prev_y;
  bit     run_parity, run_on_boundary, run_open;

  pip_pkg::pos_t   expected_positions[$];
  int              mismatches;
  int              words_sent;
  bit              idle_on;
  int              stall_cycles;
  pip_pkg::coord_t poly_x[64];
  pip_pkg::coord_t poly_y[64];

  // one edge a -> b against the held query: exact on-edge test, then the
  // half-open ray crossing decided by signs only
  function automatic void track_edge(longint ax, longint ay, longint bx, longint by);
    longint xi, yi, xj, yj, s;
    if ((bx - ax) * (run_qy - ay) - (by - ay) * (run_qx - ax) == 0 &&
        run_qx >= ((ax < bx) ? ax : bx) && run_qx <= ((ax < bx) ? bx : ax) &&
        run_qy >= ((ay < by) ? ay : by) && run_qy <= ((ay < by) ? by : ay))
      run_on_boundary = 1'b1;
    xi = bx - run_qx; yi = by - run_qy;
    xj = ax - run_qx; yj = ay - run_qy;
    if ((yi > 0 && yj <= 0) || (yj > 0 && yi <= 0)) begin
      s = xi * yj - xj * yi;
      // crossing x has the sign of s / (yj - yi); must be strictly left
      if (s != 0 && ((s > 0) == ((yi - yj) > 0)))
        run_parity = ~run_parity;
    end
  endfunction

  function automatic void track_vertex(pip_pkg::coord_t qx, pip_pkg::coord_t qy,
                                       pip_pkg::coord_t vx, pip_pkg::coord_t vy,
                                       bit last);
    longint x, y;
    x = longint'(vx);
    y = longint'(vy);
    if (!run_open) begin
      run_qx = longint'(qx);
      run_qy = longint'(qy);
      run_first_x = x;
      run_first_y = y;
      run_parity = 1'b0;
      run_on_boundary = 1'b0;
      run_open = 1'b1;
    end else begin
      track_edge(run_prev_x, run_prev_y, x, y);
    end
    run_prev_x = x;
    run_prev_y = y;
    if (last) begin
      track_edge(x, y, run_first_x, run_first_y);
      if (run_on_boundary)
        expected_positions.push_back(pip_pkg::POS_BOUNDARY);
      else
        expected_positions.push_back(run_parity ? pip_pkg::POS_INSIDE :
                                                  pip_pkg::POS_OUTSIDE);
      run_open = 1'b0;
    end
  endfunction

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_vertex(input pip_pkg::coord_t qx, input pip_pkg::coord_t qy,
                             input pip_pkg::coord_t vx, input pip_pkg::coord_t vy,
                             input bit last);
    while (idle_on && $urandom_range(99) < 31) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {vy, vx, qy, qx};
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    track_vertex(qx, qy, vx, vy, last);
    words_sent++;
    @(negedge clk);
  endtask

  // query rides on the first word; later words carry junk query fields
  task automatic send_polygon(input pip_pkg::coord_t qx, input pip_pkg::coord_t qy,
                              input int n);
    for (int i = 0; i < n; i++) begin
      if (i == 0)
        send_vertex(qx, qy, poly_x[0], poly_y[0], n == 1);
      else
        send_vertex(pip_pkg::coord_t'($urandom), pip_pkg::coord_t'($urandom),
                    poly_x[i], poly_y[i], i == n - 1);
    end
  endtask

  task automatic hold_until_drained();
    in_tvalid = 1'b0;
    while (expected_positions.size() != 0)
      @(negedge clk);
  endtask

  function automatic void load_box(int lo, int hi);
    poly_x[0] = pip_pkg::coord_t'(lo); poly_y[0] = pip_pkg::coord_t'(lo);
    poly_x[1] = pip_pkg::coord_t'(hi); poly_y[1] = pip_pkg::coord_t'(lo);
    poly_x[2] = pip_pkg::coord_t'(hi); poly_y[2] = pip_pkg::coord_t'(hi);
    poly_x[3] = pip_pkg::coord_t'(lo); poly_y[3] = pip_pkg::coord_t'(hi);
  endfunction

  function automatic pip_pkg::coord_t rand_coord(span_e span);
    case (span)
      SPAN_TINY: return pip_pkg::coord_t'(int'($urandom_range(16)) - 8);
      SPAN_MID:  return pip_pkg::coord_t'(int'($urandom_range(600)) - 300);
      SPAN_EXTREME: begin
        case ($urandom_range(4))
          0: return pip_pkg::coord_t'(-32768);
          1: return pip_pkg::coord_t'(32767);
          2: return pip_pkg::coord_t'(0);
          3: return pip_pkg::coord_t'(-1);
          default: return pip_pkg::coord_t'($urandom);
        endcase
      end
      default: return pip_pkg::coord_t'($urandom);
    endcase
  endfunction

  // single vertex run: point edge, boundary only on an exact hit
  task automatic test_single_vertex();
    poly_x[0] = 5; poly_y[0] = -7;
    send_polygon(5, -7, 1);
    poly_x[0] = 1; poly_y[0] = 0;
    send_polygon(0, 0, 1);
  endtask

  task automatic test_square();
    load_box(-10, 10);
    send_polygon(0, 0, 4);      // inside
    send_polygon(10, 3, 4);     // on right edge
  endtask

  // full-range box, query on the most negative corner and at the centre
  task automatic test_extremes();
    load_box(-32768, 32767);
    send_polygon(0, 0, 4);
    send_polygon(-32768, -32768, 4);
  endtask

  task automatic test_vertex_ray_and_repeats();
    // the query's horizontal line runs straight through the apex (10,5): half-open rule
    poly_x[0] = 0;  poly_y[0] = 0;
    poly_x[1] = 10; poly_y[1] = 5;
    poly_x[2] = 0;  poly_y[2] = 10;
    send_polygon(-5, 5, 3);
    // repeated vertex gives a zero-length edge
    poly_x[0] = 0;  poly_y[0] = 0;
    poly_x[1] = 0;  poly_y[1] = 0;
    poly_x[2] = 10; poly_y[2] = 0;
    poly_x[3] = 10; poly_y[3] = 10;
    poly_x[4] = 0;  poly_y[4] = 10;
    send_polygon(5, 5, 5);
  endtask

  task automatic send_random_polygon();
    span_e           span;
    int              n, r, k, k2;
    pip_pkg::coord_t qx, qy;
    span = span_e'($urandom_range(3));
    r = $urandom_range(99);
    if (r < 10)      n = $urandom_range(1, 2);
    else if (r < 90) n = $urandom_range(3, 8);
    else             n = $urandom_range(9, 40);
    for (int i = 0; i < n; i++) begin
      poly_x[i] = rand_coord(span);
      poly_y[i] = rand_coord(span);
    end
    k  = $urandom_range(n - 1);
    k2 = (k + 1) % n;
    r  = $urandom_range(99);
    if (r < 25) begin
      qx = poly_x[k];
      qy = poly_y[k];
    end else if (r < 45) begin
      qx = pip_pkg::coord_t'((int'(poly_x[k]) + int'(poly_x[k2])) / 2);
      qy = pip_pkg::coord_t'((int'(poly_y[k]) + int'(poly_y[k2])) / 2);
    end else begin
      qx = rand_coord(span);
      qy = rand_coord(span);
    end
    send_polygon(qx, qy, n);
  endtask

  task automatic test_random_polygons(input int target);
    int polys;
    polys = 0;
    while (words_sent < target) begin
      send_random_polygon();
      polys++;
      if (polys % 37 == 0)
        hold_until_drained();
    end
  endtask

  // no idling on either side: full-rate words and results
  task automatic test_back_to_back();
    idle_on = 1'b0;
    for (int i = 0; i < 40; i++)
      send_random_polygon();
    idle_on = 1'b1;
  endtask

  // receiver stalls at random while idling is on
  always @(negedge clk)
    out_tready = !(idle_on && $urandom_range(99) < 31);

  // position checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_positions.size() == 0) begin
        $display("%0t: position expected none, got %0d", $time,
                 out_tdata[pip_pkg::POS_BITS-1:0]);
        mismatches++;
      end else begin
        pip_pkg::pos_t want;
        want = expected_positions.pop_front();
        if (out_tdata[pip_pkg::POS_BITS-1:0] !== want) begin
          $display("%0t: position expected %0d, got %0d", $time, want,
                   out_tdata[pip_pkg::POS_BITS-1:0]);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles where neither side moves a word
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    out_tready   = 1'b0;
    idle_on      = 1'b1;
    mismatches   = 0;
    words_sent   = 0;
    stall_cycles = 0;
    run_open     = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_single_vertex();
    test_square();
    test_extremes();
    test_vertex_ray_and_repeats();
    test_random_polygons(TARGET_WORDS / 2);
    test_back_to_back();
    test_random_polygons(TARGET_WORDS);

    hold_until_drained();
    repeat (8) @(posedge clk);   // catch any stray result after the last one
    if (expected_positions.size() != 0) begin
      $display("%0t: position expected %0d more, got none", $time,
               expected_positions.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
